// ===== hw/rtl/fixed_width_decimal_formatter_unit_assert.svh =====
`ifndef FIXED_WIDTH_DECIMAL_FORMATTER_UNIT_ASSERT_SVH
`define FIXED_WIDTH_DECIMAL_FORMATTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk, quiet while arst_n is low.
`define FWDF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FWDF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/fwdf_pkg.sv =====
package fwdf_pkg;

	localparam int MAX_DIGITS = 9;
	localparam int MAX_K      = MAX_DIGITS - 1;
	localparam int K_W        = 4;
	localparam int POW_W      = 27;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIGITS  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIGITS  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_SCORE_MODE  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_SPACE = CFG_IDX_W'(3);

	localparam logic [3:0] RST_NUM_DIGITS = 4'd5;
	localparam logic [3:0] RST_MIN_DIGITS = 4'd1;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int FQ_DEPTH = 2;
	localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
	localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);
	localparam int OQ_DEPTH = 2;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	typedef struct packed {
		logic [3:0] num_digits;
		logic [3:0] min_digits;
		logic       score;
		logic       trail;
	} fwdf_cfg_t;

	typedef struct packed {
		logic [31:0] value;
		logic        shadow;
	} fwdf_item_t;

	typedef struct packed {
		logic [7:0] code;
		logic       shadow;
		logic       last;
	} fwdf_char_t;

	typedef struct packed {
		logic           start;
		logic [31:0]    v;
		logic [K_W-1:0] k;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] d16;
		logic [31:0] v_next;
	} div_rsp_t;

	function automatic logic [POW_W-1:0] pow10(input logic [K_W-1:0] k);
		case (k)
			4'd0: return 27'd1;
			4'd1: return 27'd10;
			4'd2: return 27'd100;
			4'd3: return 27'd1000;
			4'd4: return 27'd10000;
			4'd5: return 27'd100000;
			4'd6: return 27'd1000000;
			4'd7: return 27'd10000000;
			4'd8: return 27'd100000000;
			default: return 27'd1;
		endcase
	endfunction

	// floor(2^s / 10^k), scaled into [2^31, 2^32)
	function automatic logic [31:0] recip(input logic [K_W-1:0] k);
		case (k)
			4'd1: return 32'd3435973836;
			4'd2: return 32'd2748779069;
			4'd3: return 32'd2199023255;
			4'd4: return 32'd3518437208;
			4'd5: return 32'd2814749767;
			4'd6: return 32'd2251799813;
			4'd7: return 32'd3602879701;
			4'd8: return 32'd2882303761;
			default: return 32'd0;
		endcase
	endfunction

	// Quotient estimate, low by at most one
	function automatic logic [31:0] quot_est(input logic [63:0] prod, input logic [K_W-1:0] k);
		case (k)
			4'd1: return 32'(prod >> 35);
			4'd2: return 32'(prod >> 38);
			4'd3: return 32'(prod >> 41);
			4'd4: return 32'(prod >> 45);
			4'd5: return 32'(prod >> 48);
			4'd6: return 32'(prod >> 51);
			4'd7: return 32'(prod >> 55);
			4'd8: return 32'(prod >> 58);
			default: return 32'd0;
		endcase
	endfunction

endpackage

// ===== hw/rtl/fwdf_front.sv =====
module fwdf_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fwdf_pkg::fwdf_cfg_t    cfg,
	input  logic                   push,
	input  logic signed [31:0]     number_value,
	output logic                   full,
	output logic                   item_vld,
	output fwdf_pkg::fwdf_item_t   item,
	input  logic                   item_take
);

	fwdf_pkg::fwdf_item_t              fq_mem_q [fwdf_pkg::FQ_DEPTH];
	logic [fwdf_pkg::FQ_PTR_W-1:0]     wptr_q;
	logic [fwdf_pkg::FQ_PTR_W-1:0]     rptr_q;
	logic [fwdf_pkg::FQ_CNT_W-1:0]     cnt_q;
	logic [31:0]                       raw;
	logic                              drop;
	logic                              wr;
	logic                              rd;
	fwdf_pkg::fwdf_item_t              cls;

	assign raw = number_value;

	// width out of range, or nothing at all to print: the beat is swallowed
	always_comb begin
		drop = (cfg.num_digits > 4'(fwdf_pkg::MAX_DIGITS))
			|| (cfg.num_digits == 4'd0 && !cfg.trail);
		cls.shadow = !cfg.score && (raw[15:0] == 16'hFFFF);
		cls.value  = cfg.score ? raw : {16'b0, raw[15:0]};
	end

	assign full     = cnt_q == fwdf_pkg::FQ_CNT_W'(fwdf_pkg::FQ_DEPTH);
	assign item_vld = cnt_q != '0;
	assign item     = fq_mem_q[rptr_q];
	assign wr       = push && !full && !drop;
	assign rd       = item_take && item_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == fwdf_pkg::FQ_PTR_W'(fwdf_pkg::FQ_DEPTH - 1))
					? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == fwdf_pkg::FQ_PTR_W'(fwdf_pkg::FQ_DEPTH - 1))
					? '0 : rptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			fq_mem_q[wptr_q] <= cls;
		end
	end

endmodule

// ===== hw/rtl/fwdf_div.sv =====
module fwdf_div (
	input  logic                clk,
	input  logic                arst_n,
	input  fwdf_pkg::div_req_t  req,
	output fwdf_pkg::div_rsp_t  rsp
);

	`include "fixed_width_decimal_formatter_unit_assert.svh"

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic [31:0]                   v_s1, mag_s1;
	logic                          neg_s1;
	logic [fwdf_pkg::K_W-1:0]      k_s1;

	logic [63:0]                   prod_s2;
	logic [31:0]                   v_s2, mag_s2;
	logic                          neg_s2;
	logic [fwdf_pkg::K_W-1:0]      k_s2;

	logic [31:0]                   qest_s3;
	logic [27:0]                   rem_s3;
	logic [31:0]                   v_s3;
	logic                          neg_s3;
	logic [fwdf_pkg::K_W-1:0]      k_s3;

	logic [15:0]                   d16_s4;
	logic [31:0]                   v_s4;
	logic [fwdf_pkg::K_W-1:0]      k_s4;

	logic [15:0]                   d16_s5;
	logic [31:0]                   vnext_s5;

	logic [31:0]                   mag_in;
	logic [63:0]                   prod_d;
	logic [31:0]                   qest_d;
	logic [54:0]                   qd_full;
	logic [27:0]                   rem_d;
	logic                          corr;
	logic [31:0]                   q_abs;
	logic [31:0]                   q_sgn;
	logic [42:0]                   dd_full;
	logic [31:0]                   vnext_d;

	always_comb begin
		mag_in  = req.v[31] ? (~req.v + 32'd1) : req.v;
		prod_d  = {32'b0, mag_s1} * {32'b0, fwdf_pkg::recip(k_s1)};
		qest_d  = (k_s2 == '0) ? mag_s2 : fwdf_pkg::quot_est(prod_s2, k_s2);
		// remainder estimate is below 2*10^k, so 28 bits carry it exactly
		qd_full = {27'b0, qest_d[27:0]} * {28'b0, fwdf_pkg::pow10(k_s2)};
		rem_d   = mag_s2[27:0] - qd_full[27:0];
		corr    = rem_s3 >= {1'b0, fwdf_pkg::pow10(k_s3)};
		q_abs   = qest_s3 + {31'b0, corr};
		q_sgn   = neg_s3 ? (~q_abs + 32'd1) : q_abs;
		dd_full = {16'b0, fwdf_pkg::pow10(k_s4)} * {27'b0, d16_s4};
		vnext_d = v_s4 - dd_full[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= req.start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		v_s1     <= req.v;
		mag_s1   <= mag_in;
		neg_s1   <= req.v[31];
		k_s1     <= req.k;

		prod_s2  <= prod_d;
		v_s2     <= v_s1;
		mag_s2   <= mag_s1;
		neg_s2   <= neg_s1;
		k_s2     <= k_s1;

		qest_s3  <= qest_d;
		rem_s3   <= rem_d;
		v_s3     <= v_s2;
		neg_s3   <= neg_s2;
		k_s3     <= k_s2;

		d16_s4   <= q_sgn[15:0];
		v_s4     <= v_s3;
		k_s4     <= k_s3;

		d16_s5   <= d16_s4;
		vnext_s5 <= vnext_d;
	end

	assign rsp.done   = vld_s5;
	assign rsp.d16    = d16_s5;
	assign rsp.v_next = vnext_s5;

	`FWDF_ASSERT_SAME(a_div_single, req.start, !(vld_s1 || vld_s2 || vld_s3 || vld_s4), "division issued while one is in flight")
	`FWDF_ASSERT_SAME(a_div_onehot, 1'b1, $onehot0({vld_s1, vld_s2, vld_s3, vld_s4, vld_s5}), "more than one division in the pipe")
	`FWDF_ASSERT_SAME(a_div_est, vld_s3 && (k_s3 <= fwdf_pkg::K_W'(fwdf_pkg::MAX_K)), rem_s3 < ({1'b0, fwdf_pkg::pow10(k_s3)} << 1), "quotient estimate off by more than one")

endmodule

// ===== hw/rtl/fwdf_back.sv =====
module fwdf_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fwdf_pkg::fwdf_cfg_t    cfg,
	input  logic                   item_vld,
	input  fwdf_pkg::fwdf_item_t   item,
	output logic                   item_take,
	output fwdf_pkg::div_req_t     div_req,
	input  fwdf_pkg::div_rsp_t     div_rsp,
	output logic                   empty,
	input  logic                   pop,
	output fwdf_pkg::fwdf_char_t   head
);

	`include "fixed_width_decimal_formatter_unit_assert.svh"

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_HOLD,
		ST_SPACE
	} state_t;

	state_t                            state_q, state_d;
	logic [3:0]                        rem_q;
	logic                              started_q;
	logic                              shadow_q;
	fwdf_pkg::fwdf_char_t              hold_char_q;
	logic [31:0]                       hold_v_q;

	fwdf_pkg::fwdf_char_t              oq_mem_q [fwdf_pkg::OQ_DEPTH];
	logic [fwdf_pkg::OQ_PTR_W-1:0]     oq_wptr_q;
	logic [fwdf_pkg::OQ_PTR_W-1:0]     oq_rptr_q;
	logic [fwdf_pkg::OQ_CNT_W-1:0]     oq_cnt_q;
	logic                              oq_full;
	logic                              oq_push;
	logic                              oq_pop;
	fwdf_pkg::fwdf_char_t              oq_data;

	logic                              started_n;
	logic [3:0]                        dig;
	fwdf_pkg::fwdf_char_t              dig_char;
	logic [31:0]                       vn;
	logic                              adv;
	logic [31:0]                       adv_v;

	always_comb begin
		started_n     = started_q || (rem_q <= cfg.min_digits) || (div_rsp.d16 != 16'd0);
		dig           = (div_rsp.d16 > 16'd9) ? 4'd9 : div_rsp.d16[3:0];
		dig_char.code = shadow_q ? fwdf_pkg::CH_ZERO
			: started_n ? fwdf_pkg::CH_ZERO + {4'b0, dig} : fwdf_pkg::CH_SPACE;
		dig_char.shadow = shadow_q;
		dig_char.last   = (rem_q == 4'd1) && !cfg.trail;
		// 16-bit mode keeps the remainder to 16 bits
		vn    = cfg.score ? div_rsp.v_next : {16'b0, div_rsp.v_next[15:0]};
		adv_v = (state_q == ST_HOLD) ? hold_v_q : vn;
	end

	always_comb begin
		state_d     = state_q;
		item_take   = 1'b0;
		div_req     = '0;
		oq_push     = 1'b0;
		oq_data     = dig_char;
		adv         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_vld) begin
					item_take = 1'b1;
					if (cfg.num_digits == 4'd0) begin
						state_d = ST_SPACE;
					end else begin
						div_req.start = 1'b1;
						div_req.v     = item.value;
						div_req.k     = cfg.num_digits - 4'd1;
						state_d       = ST_BUSY;
					end
				end
			end
			ST_BUSY: begin
				if (div_rsp.done) begin
					if (!oq_full) begin
						oq_push = 1'b1;
						adv     = 1'b1;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (!oq_full) begin
					oq_push = 1'b1;
					oq_data = hold_char_q;
					adv     = 1'b1;
				end
			end
			ST_SPACE: begin
				if (!oq_full) begin
					oq_push        = 1'b1;
					oq_data.code   = fwdf_pkg::CH_SPACE;
					oq_data.shadow = shadow_q;
					oq_data.last   = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		// next position, or wind up the number
		if (adv) begin
			if (rem_q == 4'd1) begin
				state_d = cfg.trail ? ST_SPACE : ST_IDLE;
			end else begin
				div_req.start = 1'b1;
				div_req.v     = adv_v;
				div_req.k     = rem_q - 4'd2;
				state_d       = ST_BUSY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rem_q       <= '0;
			started_q   <= 1'b0;
			shadow_q    <= 1'b0;
			hold_char_q <= '0;
			hold_v_q    <= '0;
		end else begin
			state_q <= state_d;
			if (item_take) begin
				shadow_q  <= item.shadow;
				started_q <= 1'b0;
				rem_q     <= cfg.num_digits;
			end
			if (state_q == ST_BUSY && div_rsp.done) begin
				started_q   <= started_n;
				hold_char_q <= dig_char;
				hold_v_q    <= vn;
			end
			if (adv && rem_q != 4'd1) begin
				rem_q <= rem_q - 4'd1;
			end
		end
	end

	assign oq_full = oq_cnt_q == fwdf_pkg::OQ_CNT_W'(fwdf_pkg::OQ_DEPTH);
	assign empty   = oq_cnt_q == '0;
	assign oq_pop  = pop && !empty;
	assign head    = oq_mem_q[oq_rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wptr_q <= '0;
			oq_rptr_q <= '0;
			oq_cnt_q  <= '0;
		end else begin
			if (oq_push) begin
				oq_wptr_q <= (oq_wptr_q == fwdf_pkg::OQ_PTR_W'(fwdf_pkg::OQ_DEPTH - 1))
					? '0 : oq_wptr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rptr_q <= (oq_rptr_q == fwdf_pkg::OQ_PTR_W'(fwdf_pkg::OQ_DEPTH - 1))
					? '0 : oq_rptr_q + 1'b1;
			end
			case ({oq_push, oq_pop})
				2'b10: oq_cnt_q <= oq_cnt_q + 1'b1;
				2'b01: oq_cnt_q <= oq_cnt_q - 1'b1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_mem_q[oq_wptr_q] <= oq_data;
		end
	end

	`FWDF_ASSERT_SAME(a_done_in_busy, div_rsp.done, state_q == ST_BUSY, "division result outside busy state")
	`FWDF_ASSERT_SAME(a_rem_nonzero, state_q == ST_BUSY || state_q == ST_HOLD, rem_q != 4'd0, "position count ran out while working")
	`FWDF_ASSERT_SAME(a_oq_bound, 1'b1, oq_cnt_q <= fwdf_pkg::OQ_CNT_W'(fwdf_pkg::OQ_DEPTH), "result queue overfilled")
	`FWDF_ASSERT_NEXT(a_issue_busy, div_req.start, state_q == ST_BUSY, "division issued without waiting for it")

endmodule

// ===== hw/rtl/fixed_width_decimal_formatter_unit.sv =====
// Fixed-width decimal formatter: each number pushed in comes out as a configured count of
// ASCII digit characters, most significant position first, leading zeros shown as spaces
// above the configured count of always-shown low positions, plus one trailing space when
// enabled; last_char marks the final character of a number. A front queue (two numbers
// deep) takes numbers while the back end is still working, and a two-deep result queue
// decouples the pop side. Each digit position is one trip through a five-stage reciprocal
// division pipe, and a position needs the remainder of the one before, so the back end
// issues no new division for a number until the last one has returned, and takes up the
// next number only when the current one is done. Numbers that yield no characters, or
// whose configured width is out of range, are dropped at the input.
// Configuration must be written while the block is idle; there is no clearing pass after reset.
module fixed_width_decimal_formatter_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fwdf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fwdf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               push,
	output logic                               full,
	input  logic signed [31:0]                 number_value,
	output logic                               empty,
	input  logic                               pop,
	output logic [7:0]                         char_code,
	output logic                               suppress_shadow,
	output logic                               last_char
);

	fwdf_pkg::fwdf_cfg_t    cfg_q;
	logic                   item_vld;
	logic                   item_take;
	fwdf_pkg::fwdf_item_t   item;
	fwdf_pkg::div_req_t     div_req;
	fwdf_pkg::div_rsp_t     div_rsp;
	fwdf_pkg::fwdf_char_t   head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_digits <= fwdf_pkg::RST_NUM_DIGITS;
			cfg_q.min_digits <= fwdf_pkg::RST_MIN_DIGITS;
			cfg_q.score      <= 1'b0;
			cfg_q.trail      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				fwdf_pkg::CFG_NUM_DIGITS:  cfg_q.num_digits <= cfg_wdata;
				fwdf_pkg::CFG_MIN_DIGITS:  cfg_q.min_digits <= cfg_wdata;
				fwdf_pkg::CFG_SCORE_MODE:  cfg_q.score      <= cfg_wdata[0];
				fwdf_pkg::CFG_TRAIL_SPACE: cfg_q.trail      <= cfg_wdata[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	fwdf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.push         (push),
		.number_value (number_value),
		.full         (full),
		.item_vld     (item_vld),
		.item         (item),
		.item_take    (item_take)
	);

	fwdf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	fwdf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item_vld  (item_vld),
		.item      (item),
		.item_take (item_take),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.empty     (empty),
		.pop       (pop),
		.head      (head)
	);

	assign char_code       = head.code;
	assign suppress_shadow = head.shadow;
	assign last_char       = head.last;

endmodule
